### src/alsa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the ROM contents function for the audio level
// to servo angle block. No dependencies.
package alsa_pkg;

   localparam int LEVEL_BITS_DEF = 16;
   localparam int RATIO_BITS_DEF = 10;

   localparam int ANGLE_W    = 8;
   localparam int SILENCE_W  = 16;
   localparam int GAIN_W     = 9;
   localparam int GAIN_ONE   = 256;
   localparam int SMOOTH_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // 0.2-power ROM: values 0..ROM_SCALE
   localparam int ROM_W      = 10;
   localparam int ROM_SCALE  = 1000;
   localparam int ANGLE_OFS  = 5;

   // |rom * span| < 2^18, quotient by ROM_SCALE < 2^9
   localparam int PROD_W     = 18;
   localparam int QUO_W      = 9;
   localparam int QREM_W     = 10;
   localparam int TGT_W      = 9;
   localparam int ACCT_W     = 17;
   localparam int ACCS_W     = 24;

   localparam logic [CSR_DATA_W-1:0] MIN_ANGLE_RST   = 16'd0;
   localparam logic [CSR_DATA_W-1:0] MAX_ANGLE_RST   = 16'd180;
   localparam logic [CSR_DATA_W-1:0] SILENCE_RST     = 16'd0;
   localparam logic [CSR_DATA_W-1:0] GAIN_RST        = 16'd64;
   localparam logic [CSR_DATA_W-1:0] DEADBAND_RST    = 16'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_ANGLE,
      CSR_MAX_ANGLE,
      CSR_SILENCE_LEVEL,
      CSR_SMOOTHING_GAIN,
      CSR_DEADBAND
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROM,
      ST_MUL,
      ST_QDIV,
      ST_SM_LOAD,
      ST_SMOOTH,
      ST_SUM,
      ST_EMIT
   } state_type;

   // Largest m in 0..ROM_SCALE with (m/1000)^5 <= r / 2^rbits.
   // Evaluated at elaboration only.
   function automatic logic [ROM_W-1:0] power_rom(input int unsigned r,
                                                  input int unsigned rbits);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] m;
      logic [63:0] p;
      logic [63:0] rhs;
      lo  = 64'd0;
      hi  = 64'(ROM_SCALE);
      rhs = 64'(r) * 64'd1000000000000000;
      for (int k = 0; k < ROM_W + 1; k++) begin
         if (lo < hi) begin
            m = (lo + hi + 64'd1) >> 1;
            p = m * m * m * m * m;
            if ((p << rbits) <= rhs) begin
               lo = m;
            end else begin
               hi = m - 64'd1;
            end
         end
      end
      return lo[ROM_W-1:0];
   endfunction

endpackage

### src/audio_level_to_servo_angle_top.sv
`timescale 1ns / 1ps
// Audio level to servo angle: level/peak ratio, 0.2-power ROM, smoothing,
// clamp and deadband. Depends on alsa_pkg.
//
// Usage:
//  - req_* carries one audio level per request; rsp_* returns one servo
//    command (angle, move flag) for every request, in order.
//  - csr_* writes the five registers; csr_ready is always high. Write them
//    only while no request is in flight.
//  - A non-silent level runs through a bit-serial divider, the ROM read, a
//    shift-add multiply, a divide by 1000 and the shift-add smoothing; a
//    silent one goes straight to the smoothing. All of it handles one item
//    at a time.
//  - req_tready is high while the datapath is free, also while a finished
//    response waits in the output register; a new request can be taken in
//    the cycle after the previous one reaches the output register.
//  - A stalled rsp_tready holds the response; the next item then waits in
//    its final step until the output register frees up.
//  - Synchronous reset clears the registers to their defaults, the peak,
//    the smoothed angle and the last written angle.
module audio_level_to_servo_angle_top #(
   parameter int LEVEL_BITS = alsa_pkg::LEVEL_BITS_DEF,
   parameter int RATIO_BITS = alsa_pkg::RATIO_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // request: level [LEVEL_BITS-1:0], zero padded to bytes
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((LEVEL_BITS + 7) / 8) * 8 - 1:0]       req_tdata,
   // response: angle [7:0]
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [alsa_pkg::ANGLE_W-1:0]                  rsp_tdata,
   // response: move [0]
   output logic                                          rsp_tuser,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [alsa_pkg::CSR_IDX_W-1:0]                csr_index,
   input  logic [alsa_pkg::CSR_DATA_W-1:0]               csr_data
);

   import alsa_pkg::*;

   localparam int LW        = LEVEL_BITS;
   localparam int RW        = RATIO_BITS;
   localparam int CMP_W     = (LW > SILENCE_W) ? LW : SILENCE_W;
   localparam int ROM_DEPTH = (2 ** RW) + 1;
   localparam int STEP_MAX  = (RW > ROM_W - 1) ? RW : ROM_W - 1;
   localparam int STEP_W    = $clog2(STEP_MAX + 1);

   // configuration
   logic [ANGLE_W-1:0]   min_angle_ff;
   logic [ANGLE_W-1:0]   max_angle_ff;
   logic [SILENCE_W-1:0] silence_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [ANGLE_W-1:0]   deadband_ff;

   // persistent state
   logic [LW-1:0]        peak_ff;
   logic [SMOOTH_W-1:0]  smoothed_ff;
   logic [ANGLE_W-1:0]   last_ff;

   // control
   state_type            state_ff;
   state_type            state_in;
   logic [STEP_W-1:0]    step_ff;
   logic                 rsp_tvalid_ff;
   logic                 req_fire;
   logic                 emit_go;
   logic                 step_last;

   // datapath
   logic [LW:0]          rem_ff;
   logic [RW:0]          q_ff;
   logic [ROM_W-1:0]     mplier_ff;
   logic [PROD_W-1:0]    mcand_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 span_neg_ff;
   logic [TGT_W-1:0]     lo_ff;
   logic [QREM_W-1:0]    qrem_ff;
   logic [QUO_W-1:0]     qsh_ff;
   logic [TGT_W-1:0]     tgt_ff;
   logic [GAIN_W-1:0]    gm_ff;
   logic [GAIN_W-1:0]    hm_ff;
   logic [ACCT_W-1:0]    tsh_ff;
   logic [ACCS_W-1:0]    ssh_ff;
   logic [ACCT_W-1:0]    acct_ff;
   logic [ACCS_W-1:0]    accs_ff;
   logic [ANGLE_W-1:0]   angle_ff;
   logic                 move_ff;

   logic [ROM_W-1:0]     rom_mem [ROM_DEPTH];

   // combinational helpers
   logic [LW-1:0]        level;
   logic                 silent;
   logic                 div_ge;
   logic [LW:0]          div_diff;
   logic [TGT_W-1:0]     lo_w;
   logic [TGT_W:0]       span;
   logic [TGT_W:0]       span_abs;
   logic [PROD_W-1:0]    prod_in;
   logic [QREM_W:0]      qtrial;
   logic                 q_ge;
   logic [QUO_W-1:0]     quot;
   logic [GAIN_W-1:0]    g_sat;
   logic [ACCS_W-1:0]    rnd;
   logic [PROD_W-1:0]    sum;
   logic [SMOOTH_W:0]    cand_rnd;
   logic [TGT_W-1:0]     cand_raw;
   logic [ANGLE_W-1:0]   cand;
   logic [ANGLE_W:0]     diff;
   logic [ANGLE_W:0]     diff_abs;
   logic                 do_move;

   // ROM contents computed at elaboration
   for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
      localparam logic [ROM_W-1:0] ROM_VAL = power_rom(i, RW);
      assign rom_mem[i] = ROM_VAL;
   end

   assign level  = req_tdata[LW-1:0];
   assign silent = CMP_W'(level) < CMP_W'(silence_ff);

   // ratio divider step
   assign div_ge   = (rem_ff >= {1'b0, peak_ff}) && (|peak_ff);
   assign div_diff = rem_ff - {1'b0, peak_ff};

   // span = max - (min + 5), signed
   assign lo_w     = {1'b0, min_angle_ff} + TGT_W'(ANGLE_OFS);
   assign span     = {2'b00, max_angle_ff} - {1'b0, lo_w};
   assign span_abs = span[TGT_W] ? (~span + 1'b1) : span;

   assign prod_in = mplier_ff[0] ? (prod_ff + mcand_ff) : prod_ff;

   // divide by 1000, one quotient bit per cycle
   assign qtrial = {qrem_ff, qsh_ff[QUO_W-1]};
   assign q_ge   = qtrial >= (QREM_W + 1)'(ROM_SCALE);
   assign quot   = {qsh_ff[QUO_W-2:0], q_ge};

   assign g_sat = (gain_ff > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain_ff;

   assign rnd = accs_ff + ACCS_W'(128);
   assign sum = PROD_W'(acct_ff) + PROD_W'(rnd[ACCS_W-1:8]);

   // round, clamp (on inverted limits below min gives min, else max), deadband
   assign cand_rnd = {1'b0, smoothed_ff} + (SMOOTH_W + 1)'(128);
   assign cand_raw = cand_rnd[SMOOTH_W:8];
   always_comb begin
      if (cand_raw < {1'b0, min_angle_ff}) begin
         cand = min_angle_ff;
      end else if (cand_raw > {1'b0, max_angle_ff}) begin
         cand = max_angle_ff;
      end else begin
         cand = cand_raw[ANGLE_W-1:0];
      end
   end
   assign diff     = {1'b0, cand} - {1'b0, last_ff};
   assign diff_abs = diff[ANGLE_W] ? (~diff + 1'b1) : diff;
   assign do_move  = diff_abs > {1'b0, deadband_ff};

   assign step_last = (step_ff == '0);

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      emit_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EMIT: begin
            emit_go = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign req_fire = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = silent ? ST_SM_LOAD : ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_last) state_in = ST_ROM;
         end
         ST_ROM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_last) state_in = ST_QDIV;
         end
         ST_QDIV: begin
            if (step_last) state_in = ST_SM_LOAD;
         end
         ST_SM_LOAD: begin
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            if (step_last) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         min_angle_ff  <= MIN_ANGLE_RST[ANGLE_W-1:0];
         max_angle_ff  <= MAX_ANGLE_RST[ANGLE_W-1:0];
         silence_ff    <= SILENCE_RST[SILENCE_W-1:0];
         gain_ff       <= GAIN_RST[GAIN_W-1:0];
         deadband_ff   <= DEADBAND_RST[ANGLE_W-1:0];
         peak_ff       <= '0;
         smoothed_ff   <= '0;
         last_ff       <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_ANGLE:      min_angle_ff <= csr_data[ANGLE_W-1:0];
               CSR_MAX_ANGLE:      max_angle_ff <= csr_data[ANGLE_W-1:0];
               CSR_SILENCE_LEVEL:  silence_ff   <= csr_data[SILENCE_W-1:0];
               CSR_SMOOTHING_GAIN: gain_ff      <= csr_data[GAIN_W-1:0];
               CSR_DEADBAND:       deadband_ff  <= csr_data[ANGLE_W-1:0];
               default: begin
               end
            endcase
         end

         // silent frames leave the peak alone
         if (req_fire && !silent && (level > peak_ff)) begin
            peak_ff <= level;
         end

         if (state_ff == ST_SUM) begin
            smoothed_ff <= (|sum[PROD_W-1:SMOOTH_W]) ? '1 : sum[SMOOTH_W-1:0];
         end

         if (emit_go && do_move) begin
            last_ff <= cand;
         end

         if (emit_go) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath shift registers and accumulators
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            rem_ff  <= {1'b0, level};
            tgt_ff  <= {1'b0, min_angle_ff};
            step_ff <= STEP_W'(RW);
         end
         ST_DIV: begin
            rem_ff  <= div_ge ? {div_diff[LW-1:0], 1'b0} : {rem_ff[LW-1:0], 1'b0};
            q_ff    <= {q_ff[RW-1:0], div_ge};
            step_ff <= step_ff - 1'b1;
         end
         ST_ROM: begin
            mplier_ff   <= rom_mem[q_ff];
            mcand_ff    <= PROD_W'(span_abs);
            prod_ff     <= '0;
            span_neg_ff <= span[TGT_W];
            lo_ff       <= lo_w;
            step_ff     <= STEP_W'(ROM_W - 1);
         end
         ST_MUL: begin
            prod_ff   <= prod_in;
            mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[ROM_W-1:1]};
            qrem_ff   <= QREM_W'(prod_in[PROD_W-1:QUO_W]);
            qsh_ff    <= prod_in[QUO_W-1:0];
            step_ff   <= step_last ? STEP_W'(QUO_W - 1) : step_ff - 1'b1;
         end
         ST_QDIV: begin
            qrem_ff <= q_ge ? QREM_W'(qtrial - (QREM_W + 1)'(ROM_SCALE))
                            : qtrial[QREM_W-1:0];
            qsh_ff  <= quot;
            tgt_ff  <= span_neg_ff ? (lo_ff - quot) : (lo_ff + quot);
            step_ff <= step_ff - 1'b1;
         end
         ST_SM_LOAD: begin
            gm_ff   <= g_sat;
            hm_ff   <= GAIN_W'(GAIN_ONE) - g_sat;
            tsh_ff  <= ACCT_W'(tgt_ff);
            ssh_ff  <= ACCS_W'(smoothed_ff);
            acct_ff <= '0;
            accs_ff <= '0;
            step_ff <= STEP_W'(GAIN_W - 1);
         end
         ST_SMOOTH: begin
            if (gm_ff[0]) acct_ff <= acct_ff + tsh_ff;
            if (hm_ff[0]) accs_ff <= accs_ff + ssh_ff;
            gm_ff   <= {1'b0, gm_ff[GAIN_W-1:1]};
            hm_ff   <= {1'b0, hm_ff[GAIN_W-1:1]};
            tsh_ff  <= {tsh_ff[ACCT_W-2:0], 1'b0};
            ssh_ff  <= {ssh_ff[ACCS_W-2:0], 1'b0};
            step_ff <= step_ff - 1'b1;
         end
         ST_EMIT: begin
            if (emit_go) begin
               angle_ff <= do_move ? cand : last_ff;
               move_ff  <= do_move;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = angle_ff;
   assign rsp_tuser  = move_ff;
   assign csr_ready  = 1'b1;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for audio_level_to_servo_angle_top: streams audio levels,
// predicts each servo command and checks responses in order.
// Depends on alsa_pkg and the top-level RTL.
module testbench;
   import alsa_pkg::*;

   localparam int RATIO_ONE    = 1 << RATIO_BITS_DEF;
   localparam int CSR_COUNT    = 5;
   localparam int SETTLE_CYC   = 60;    // > worst-case request-to-response latency
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_GAP      = 12;
   localparam int PRINT_LIMIT  = 50;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               move;
   } servo_cmd_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [15:0]              req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [ANGLE_W-1:0]       rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   audio_level_to_servo_angle_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- predictor state ----------------
   logic [7:0]  cfg_min      = 8'd0;
   logic [7:0]  cfg_max      = 8'd180;
   logic [15:0] cfg_silence  = 16'd0;
   logic [8:0]  cfg_gain     = 9'd64;
   logic [7:0]  cfg_deadband = 8'd1;
   logic [15:0] peak_seen    = 16'd0;
   int          smooth_q88   = 0;
   logic [7:0]  last_cmd_angle = 8'd0;
   int          pow_table [0:RATIO_ONE];

   logic [15:0]   level_pending [$];
   servo_cmd_type cmd_expected [$];
   int            mismatch_count = 0;
   bit            no_idle = 1'b0;
   logic          level_taken = 1'b0;
   logic          rsp_taken = 1'b0;
   int            req_gap = 0;
   int            rsp_wait = 0;
   int            idle_cycles = 0;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // floor(1000 * (r / 2^RATIO_BITS)^0.2), built by walking m upward with r
   task automatic build_pow_table();
      longint unsigned m;
      longint unsigned nxt;
      longint unsigned p;
      m = 0;
      for (int r = 0; r <= RATIO_ONE; r++) begin
         while (m < ROM_SCALE) begin
            nxt = m + 1;
            p = nxt * nxt * nxt * nxt * nxt;
            if ((p << RATIO_BITS_DEF) <= longint'(r) * 64'd1000000000000000)
               m = nxt;
            else
               break;
         end
         pow_table[r] = int'(m);
      end
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_MIN_ANGLE:      cfg_min      = value[7:0];
         CSR_MAX_ANGLE:      cfg_max      = value[7:0];
         CSR_SILENCE_LEVEL:  cfg_silence  = value[15:0];
         CSR_SMOOTHING_GAIN: cfg_gain     = value[8:0];
         CSR_DEADBAND:       cfg_deadband = value[7:0];
         default: ;
      endcase
   endtask

   function automatic servo_cmd_type predict_cmd(input logic [15:0] level);
      servo_cmd_type cmd;
      int          target;
      int          base;
      int          span;
      int          gain;
      int          cand;
      int          diff;
      int          ratio;
      longint      acc;
      ratio = 0;
      if (level < cfg_silence) begin
         target = int'(cfg_min);
      end else begin
         base = int'(cfg_min) + ANGLE_OFS;
         span = int'(cfg_max) - base;
         if (level > peak_seen)
            peak_seen = level;
         if (peak_seen != 0)
            ratio = (int'(level) << RATIO_BITS_DEF) / int'(peak_seen);
         target = base + (pow_table[ratio] * span) / ROM_SCALE;
      end
      gain = (int'(cfg_gain) > GAIN_ONE) ? GAIN_ONE : int'(cfg_gain);
      acc = longint'(gain) * target * 256
            + longint'(GAIN_ONE - gain) * smooth_q88 + 128;
      acc = acc >>> 8;
      if (acc < 0)
         acc = 0;
      if (acc > 65535)
         acc = 65535;
      smooth_q88 = int'(acc);
      // lower bound first: on inverted limits below min gives min, else max
      cand = (smooth_q88 + 128) >>> 8;
      if (cand < int'(cfg_min))
         cand = int'(cfg_min);
      else if (cand > int'(cfg_max))
         cand = int'(cfg_max);
      diff = cand - int'(last_cmd_angle);
      if (diff < 0)
         diff = -diff;
      if (diff > int'(cfg_deadband)) begin
         last_cmd_angle = cand[7:0];
         cmd.move = 1'b1;
      end else begin
         cmd.move = 1'b0;
      end
      cmd.angle = last_cmd_angle;
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || level_taken) begin
         if (req_tvalid)
            req_gap = draw_gap();
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (level_pending.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= level_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- response receiver ----------------
   // stall counts down only while a response is waiting
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_tvalid && !rsp_tready) begin
         if (rsp_wait > 0)
            rsp_wait--;
         else
            rsp_tready <= 1'b1;
      end else if (rsp_taken) begin
         rsp_wait = draw_gap();
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready && rsp_wait == 0) begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin : monitor
      servo_cmd_type want;
      if (reset) begin
         level_taken <= 1'b0;
         rsp_taken   <= 1'b0;
      end else begin
         level_taken <= req_tvalid && req_tready;
         rsp_taken   <= rsp_tvalid && rsp_tready;
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_expected.size() == 0) begin
               report_mismatch("unexpected response angle", rsp_tdata, -1);
            end else begin
               want = cmd_expected.pop_front();
               if (rsp_tdata !== want.angle)
                  report_mismatch("angle", rsp_tdata, want.angle);
               if (rsp_tuser !== want.move)
                  report_mismatch("move", rsp_tuser, want.move);
            end
         end
         if (req_tvalid && req_tready)
            cmd_expected.push_back(predict_cmd(req_tdata[15:0]));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- sequencing ----------------
   task automatic wait_drained();
      while (level_pending.size() != 0 || req_tvalid || cmd_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] min_a, input logic [15:0] max_a,
                             input logic [15:0] silence, input logic [15:0] gain,
                             input logic [15:0] dband);
      wait_drained();
      write_reg(CSR_MIN_ANGLE, min_a);
      write_reg(CSR_MAX_ANGLE, max_a);
      write_reg(CSR_SILENCE_LEVEL, silence);
      write_reg(CSR_SMOOTHING_GAIN, gain);
      write_reg(CSR_DEADBAND, dband);
      // unused indexes must not disturb anything
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_W'(CSR_COUNT + $urandom_range(0, 2)), 16'($urandom));
   endtask

   function automatic logic [15:0] junk_high();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255) << 8) : 16'd0;
   endfunction

   initial begin : stimulus
      int          base;
      int          jitter;
      int          lvl;
      logic [15:0] min_a;
      logic [15:0] max_a;
      logic [15:0] silence;
      logic [15:0] gain;
      logic [15:0] dband;

      build_pow_table();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults; first levels hit the zero-peak case
      level_pending.push_back(16'd0);
      level_pending.push_back(16'd0);
      level_pending.push_back(16'd1);
      level_pending.push_back(16'hFFFF);
      level_pending.push_back(16'h8000);
      level_pending.push_back(16'd1024);
      level_pending.push_back(16'd64);
      level_pending.push_back(16'hAAAA);
      level_pending.push_back(16'h5555);

      // gain above one saturates, zero deadband
      set_config(16'd0, 16'd180, 16'd0, 16'd511, 16'd0);
      level_pending.push_back(16'hFFFF);
      level_pending.push_back(16'd0);
      level_pending.push_back(16'd40000);

      // inverted limits
      set_config(16'd180, 16'd0, 16'd0, 16'd256, 16'd1);
      level_pending.push_back(16'hFFFF);
      level_pending.push_back(16'd100);

      // silence threshold edges; a silent frame leaves the peak alone
      set_config(16'd20, 16'd160, 16'd1000, 16'd128, 16'd5);
      level_pending.push_back(16'd999);
      level_pending.push_back(16'd1000);
      level_pending.push_back(16'd0);
      level_pending.push_back(16'hFFFF);
      level_pending.push_back(16'd500);

      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin
               min_a = 0; max_a = 0; silence = 0; gain = 0; dband = 0;
            end
            1: begin
               min_a = 255; max_a = 255; silence = 16'hFFFF; gain = 511; dband = 255;
            end
            2: begin
               min_a = 180; max_a = 180; silence = 1; gain = 256; dband = 180;
            end
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  min_a = $urandom_range(0, 60);
                  max_a = $urandom_range(min_a + 10, 180);
               end else begin
                  min_a = $urandom_range(0, 255);
                  max_a = $urandom_range(0, 255);
               end
               min_a |= junk_high();
               max_a |= junk_high();
               case ($urandom_range(0, 5))
                  0: silence = 0;
                  1: silence = 16'($urandom);
                  default: silence = $urandom_range(0, 8000);
               endcase
               case ($urandom_range(0, 7))
                  0: gain = 0;
                  1: gain = 1;
                  2: gain = 257;
                  3: gain = $urandom_range(0, 511) | junk_high();
                  default: gain = $urandom_range(16, 256);
               endcase
               dband = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 6);
               dband |= junk_high();
            end
         endcase
         set_config(min_a, max_a, silence, gain, dband);
         no_idle = ($urandom_range(0, 3) == 0);

         // speech-like envelope around a drifting base, with noise frames
         base = $urandom_range(0, 65535);
         for (int n = 0; n < 55; n++) begin
            case ($urandom_range(0, 9))
               0: lvl = (cfg_silence > 0) ? $urandom_range(0, cfg_silence - 1) : 0;
               1: lvl = $urandom_range(0, 65535);
               2: lvl = 65535;
               3: lvl = $urandom_range(0, 3);
               default: begin
                  jitter = base / 4 + 1;
                  base = base + $urandom_range(0, 2 * jitter) - jitter;
                  if (base < 0)
                     base = 0;
                  if (base > 65535)
                     base = 65535;
                  lvl = base;
               end
            endcase
            level_pending.push_back(16'(lvl));
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
src/alsa_pkg.sv
src/audio_level_to_servo_angle_top.sv
tb/testbench.sv
